FILE: design/bgcd_pkg.sv
// Shared constants, types and operation codes for the binary GCD block.
package bgcd_pkg;

    localparam int FIELD_WIDTH = 64;
    localparam int WORD_WIDTH  = 64;
    localparam int TWOS_W      = $clog2(WORD_WIDTH);
    localparam logic [TWOS_W-1:0] TWOS_MAX = TWOS_W'(WORD_WIDTH - 1);

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [TWOS_W-1:0]     twos_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_BOTH,
        OP_SHIFT_X,
        OP_SHIFT_Y,
        OP_SUB
    } alu_op_t;

    typedef struct packed {
        word_t x;
        word_t y;
    } alu_res_t;

endpackage

FILE: design/bgcd_alu.sv
// Shared shift, compare and subtract unit for the GCD sequencer.
module bgcd_alu
    import bgcd_pkg::*;
(
    input  alu_op_t  op,
    input  word_t    x,
    input  word_t    y,
    output alu_res_t res
);

    logic  x_gt_y;
    word_t big;
    word_t small_val;

    always_comb begin
        x_gt_y    = (x > y);
        big       = x_gt_y ? x : y;
        small_val = x_gt_y ? y : x;
        res.x     = x;
        res.y     = y;
        case (op)
            OP_HOLD: begin
                res.x = x;
                res.y = y;
            end
            OP_SHIFT_BOTH: begin
                res.x = x >> 1;
                res.y = y >> 1;
            end
            OP_SHIFT_X: begin
                res.x = x >> 1;
            end
            OP_SHIFT_Y: begin
                res.y = y >> 1;
            end
            OP_SUB: begin
                res.x = small_val;
                res.y = big - small_val;
            end
            default: begin
                res.x = x;
                res.y = y;
            end
        endcase
    end

endmodule

FILE: design/binary_gcd_64.sv
// Top level: binary GCD sequencer around one shared shift/subtract unit.
// Steps: zero check (a zero operand goes straight to the result), removal of common factors
// of two, removal of factors of two from x, then a loop that shifts y or subtracts.
// Requests are taken only in idle, one at a time; a held result stalls ST_DONE.
// A new request is taken while a finished result still waits in the output register.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
module binary_gcd_64
    import bgcd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*FIELD_WIDTH-1:0] s_tdata,   // first_value, second_value
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [FIELD_WIDTH-1:0]   m_tdata    // divisor
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZCHK,
        ST_COMMON,
        ST_STRIPX,
        ST_LOOP,
        ST_DONE
    } state_t;

    state_t   state_reg, state_next;
    word_t    x_reg, x_next;
    word_t    y_reg, y_next;
    twos_t    twos_reg, twos_next;
    word_t    out_reg, out_next;
    logic     m_tvalid_reg, m_tvalid_next;
    alu_op_t  op;
    alu_res_t alu_res;

    bgcd_alu u_alu (
        .op  (op),
        .x   (x_reg),
        .y   (y_reg),
        .res (alu_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = FIELD_WIDTH'(out_reg);

    always_comb begin
        state_next    = state_reg;
        op            = OP_HOLD;
        twos_next     = twos_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        x_next = alu_res.x;
        y_next = alu_res.y;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata[WORD_WIDTH-1:0];
                    y_next     = s_tdata[FIELD_WIDTH +: WORD_WIDTH];
                    twos_next  = '0;
                    state_next = ST_ZCHK;
                end
            end
            ST_ZCHK: begin
                if (x_reg == '0) begin
                    x_next     = y_reg;
                    state_next = ST_DONE;
                end else if (y_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_COMMON;
                end
            end
            ST_COMMON: begin
                if (!(x_reg[0] | y_reg[0]) && (twos_reg != TWOS_MAX)) begin
                    op        = OP_SHIFT_BOTH;
                    twos_next = twos_reg + twos_t'(1);
                end else begin
                    state_next = ST_STRIPX;
                end
            end
            ST_STRIPX: begin
                if (!x_reg[0]) begin
                    op = OP_SHIFT_X;
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (y_reg == '0) begin
                    state_next = ST_DONE;
                end else if (!y_reg[0]) begin
                    op = OP_SHIFT_Y;
                end else begin
                    op = OP_SUB;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = x_reg << twos_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        twos_reg <= twos_next;
        out_reg  <= out_next;
    end

    a_accept_to_zchk: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_ZCHK))
        else $error("accepted request did not start the zero check");

    a_loop_x_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP) |-> x_reg[0])
        else $error("x is even inside the subtract loop");

    a_x_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STRIPX || state_reg == ST_LOOP) |-> (x_reg != '0))
        else $error("x is zero while stripping or subtracting");

    a_done_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_tvalid || m_tready)) |=>
        (m_tvalid && state_reg == ST_IDLE))
        else $error("finished result not moved to the output register");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for binary_gcd_64: directed table, then random operand pairs.
module tb;
    import bgcd_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 225;
    localparam int HOLD_CYCLES   = 400;
    localparam int BURST_ITEMS   = 12;
    localparam int TAIL_CYCLES   = 2 * WORD_WIDTH + 64;
    localparam int IDLE_LIMIT    = 4000;
    localparam int NUM_PHASES    = 4;
    localparam int NUM_DIRECTED  = 21;
    localparam word_t ALL_ONES   = '1;
    localparam word_t TOP_BIT    = word_t'(1) << (WORD_WIDTH - 1);

    typedef struct packed {
        word_t first;
        word_t second;
        logic  typed;
        word_t divisor;
    } gcd_case_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [2*FIELD_WIDTH-1:0] s_tdata;   // first_value, second_value
    logic                     m_tvalid;
    logic                     m_tready;
    logic [FIELD_WIDTH-1:0]   m_tdata;   // divisor

    word_t expected_gcd_q[$];
    int    error_count = 0;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    hold_req = 1'b0;
    bit    hold_ack = 1'b0;
    int    hold_left = 0;
    int    quiet_cycles = 0;

    int phase_send_idle [NUM_PHASES] = '{0, 63, 0, 35};
    int phase_recv_stall[NUM_PHASES] = '{0, 0, 63, 35};

    gcd_case_t directed_cases[NUM_DIRECTED] = '{
        '{64'd0, 64'd0, 1'b1, 64'd0},
        '{64'd0, 64'hDEAD_BEEF_0123_4567, 1'b1, 64'hDEAD_BEEF_0123_4567},
        '{ALL_ONES, 64'd0, 1'b1, ALL_ONES},
        '{64'd0, ALL_ONES, 1'b1, ALL_ONES},
        '{ALL_ONES, ALL_ONES, 1'b1, ALL_ONES},
        '{64'd1, ALL_ONES, 1'b1, 64'd1},
        '{ALL_ONES, 64'd1, 1'b1, 64'd1},
        '{TOP_BIT, TOP_BIT, 1'b1, TOP_BIT},
        '{TOP_BIT, 64'd1, 1'b1, 64'd1},
        '{TOP_BIT, TOP_BIT >> 1, 1'b1, TOP_BIT >> 1},
        '{64'd1, 64'd1, 1'b1, 64'd1},
        '{ALL_ONES, ALL_ONES - 1, 1'b1, 64'd1},
        '{64'd2, 64'd0, 1'b1, 64'd2},
        '{64'd12, 64'd18, 1'b0, 64'd0},
        '{TOP_BIT, 64'd3 << 40, 1'b0, 64'd0},
        '{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
        '{64'hFFFF_FFFF_FFFF_FFC5, 64'd2, 1'b0, 64'd0},
        '{64'd12200160415121876738, 64'd7540113804746346429, 1'b0, 64'd0},
        '{64'd3 << 62, 64'd6, 1'b0, 64'd0}
    };

    binary_gcd_64 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic word_t stein_gcd(word_t a, word_t b);
        word_t x;
        word_t y;
        word_t t;
        int    twos;
        x = a;
        y = b;
        twos = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 1) == 0 && twos < WORD_WIDTH - 1) begin
            x = x >> 1;
            y = y >> 1;
            twos++;
        end
        while ((x & 1) == 0) x = x >> 1;
        do begin
            while ((y & 1) == 0) y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end while (y != 0);
        return x << twos;
    endfunction

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic make_pair(output word_t a, output word_t b);
        word_t g;
        int    k;
        case ($urandom_range(9))
            0, 1, 2: begin
                a = rand_word();
                b = rand_word();
            end
            3, 4: begin
                g = rand_word() >> $urandom_range(40, 63);
                k = $urandom_range(0, 20);
                a = (g * word_t'($urandom_range(1, 1000))) << k;
                b = (g * word_t'($urandom_range(1, 1000))) << k;
            end
            5: begin
                a = $urandom_range(1) ? rand_word() : 0;
                b = (a == 0) ? rand_word() : 0;
            end
            6: begin
                a = rand_word() << $urandom_range(63);
                b = rand_word() << $urandom_range(63);
            end
            7: begin
                a = rand_word();
                b = $urandom_range(1) ? a : a + 1;
            end
            8: begin
                a = word_t'($urandom_range(0, 255));
                b = word_t'($urandom_range(0, 255));
            end
            default: begin
                case ($urandom_range(3))
                    0: a = ALL_ONES;
                    1: a = 1;
                    2: a = TOP_BIT;
                    default: a = rand_word();
                endcase
                case ($urandom_range(3))
                    0: b = ALL_ONES;
                    1: b = TOP_BIT >> $urandom_range(63);
                    2: b = 0;
                    default: b = rand_word();
                endcase
            end
        endcase
    endtask

    task automatic send_request(word_t a, word_t b, word_t divisor);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_gcd_q.push_back(divisor);
        @(negedge aclk);
    endtask

    task automatic send_random(int count);
        word_t a;
        word_t b;
        for (int i = 0; i < count; i++) begin
            make_pair(a, b);
            send_request(a, b, stein_gcd(a, b));
        end
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_gcd_q.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_gcd_q.size() == 0) begin
                $error("divisor with no request pending: got %h", m_tdata);
                error_count++;
            end else if (m_tdata !== expected_gcd_q[0]) begin
                $error("divisor mismatch: expected %h, got %h", expected_gcd_q[0], m_tdata);
                error_count++;
                void'(expected_gcd_q.pop_front());
            end else begin
                void'(expected_gcd_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            if (p == 0) begin
                foreach (directed_cases[i]) begin
                    send_request(directed_cases[i].first, directed_cases[i].second,
                                 directed_cases[i].typed ? directed_cases[i].divisor
                                 : stein_gcd(directed_cases[i].first,
                                             directed_cases[i].second));
                end
                drain_results();
                hold_req = !hold_req;
                send_random(BURST_ITEMS);
                drain_results();
            end
            send_random(RANDOM_ITEMS);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_gcd_q.size() != 0) begin
            $error("divisor never arrived: %0d requests outstanding", expected_gcd_q.size());
        end
        if (error_count == 0 && expected_gcd_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
